// ===== rtl/sutc_pkg.sv =====
// Shared types and constants for the sorted unique tag collector.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sutc_pkg;

    localparam int SUTC_MAX_TAGS = 64;
    localparam int TAG_W         = 32;
    localparam int CAP_W         = 7;
    localparam int CNT_W         = 7;
    localparam int STAT_W        = 2;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 7'd127;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture the incoming transaction
        logic clr_idx;
        logic inc_idx;
        logic rd_idx;     // read the store at the scan index
        logic rd_shift;   // read the store one below the shift pointer
        logic set_pos;    // insertion point is the scan index
        logic set_j;      // shift pointer starts at the stored count
        logic dec_j;
        logic wr_shift;   // move the entry just read up by one
        logic wr_ins;     // write the new tag at the shift pointer
        logic inc_count;
        logic set_ovf;
        logic clear_set;
        logic emit_status;
        logic emit_tag;
    } t_sutc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_eq_count;
        logic data_lt;
        logic data_eq;
        logic full;
        logic j_eq_pos;
        logic last_flag;
        logic ovf;
        logic gt_cap;
        logic count_zero;
        logic emit_last;
    } t_sutc_stat;

endpackage

// ===== rtl/sorted_unique_tag_collector.sv =====
// Top level of the sorted unique tag collector.
// Depends on sutc_pkg, sutc_ctrl and sutc_dp (which holds sutc_ram).
`timescale 1ns / 1ps

// A tag is taken when start is high and busy is low; the block then stays
// busy while it places the tag. The search reads the stored tags below it
// one at a time; then each stored tag above it is read and written back one
// place higher, in a read state and a write state. The next tag can be taken
// in the first cycle that busy is low.
// On the tag flagged last, the set is sent one result at a time in ascending
// order, or as a single status result, and then cleared. Results
// appear on o_strobe for one cycle each and cannot be held off, so the
// receiver must take every strobed transaction. No clearing pass follows
// reset: the store is only read below the held count.
module sorted_unique_tag_collector
    import sutc_pkg::*;
#(
    parameter int MAX_TAGS = SUTC_MAX_TAGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic              i_last_of_list,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output logic              o_strobe,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic              o_has_tag,
    output logic [CNT_W-1:0]  o_total_count,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last
);

    t_sutc_cmd  cmd;
    t_sutc_stat stat;

    sutc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    sutc_dp #(
        .MAX_TAGS(MAX_TAGS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (i_tag),
        .i_last_of_list(i_last_of_list),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_out_tag     (o_out_tag),
        .o_has_tag     (o_has_tag),
        .o_total_count (o_total_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== rtl/sutc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sutc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sutc_ctrl.sv =====
// Controller state machine of the sorted unique tag collector.
// Depends on sutc_pkg for the command and status structs.
`timescale 1ns / 1ps

module sutc_ctrl
    import sutc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_sutc_stat i_stat,
    output t_sutc_cmd  o_cmd,
    output logic       o_busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;
    localparam logic [3:0] S_SCHK   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_SHRD   = 4'd4;
    localparam logic [3:0] S_SHWR   = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_ERD    = 4'd7;
    localparam logic [3:0] S_EOUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_sutc_cmd  cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load_in = 1'b1;
                    cmd.clr_idx = 1'b1;
                    n_state     = S_SRD;
                end
            end
            S_SRD: begin
                if (i_stat.idx_eq_count) begin
                    // Every stored tag is below the new one: append at the end.
                    cmd.set_pos = 1'b1;
                    n_state     = S_DECIDE;
                end else begin
                    cmd.rd_idx = 1'b1;
                    n_state    = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_stat.data_lt) begin
                    cmd.inc_idx = 1'b1;
                    n_state     = S_SRD;
                end else if (i_stat.data_eq) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.set_pos = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.full) begin
                    cmd.set_ovf = 1'b1;
                    n_state     = S_FINISH;
                end else begin
                    cmd.set_j = 1'b1;
                    n_state   = S_SHRD;
                end
            end
            S_SHRD: begin
                if (i_stat.j_eq_pos) begin
                    cmd.wr_ins    = 1'b1;
                    cmd.inc_count = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    cmd.rd_shift = 1'b1;
                    n_state      = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.wr_shift = 1'b1;
                cmd.dec_j    = 1'b1;
                n_state      = S_SHRD;
            end
            S_FINISH: begin
                if (!i_stat.last_flag) begin
                    n_state = S_IDLE;
                end else if (i_stat.ovf || i_stat.gt_cap || i_stat.count_zero) begin
                    cmd.emit_status = 1'b1;
                    cmd.clear_set   = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    cmd.clr_idx = 1'b1;
                    n_state     = S_ERD;
                end
            end
            S_ERD: begin
                cmd.rd_idx = 1'b1;
                n_state    = S_EOUT;
            end
            S_EOUT: begin
                cmd.emit_tag = 1'b1;
                if (i_stat.emit_last) begin
                    cmd.clear_set = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.inc_idx = 1'b1;
                    n_state     = S_ERD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/sutc_dp.sv =====
// Datapath of the sorted unique tag collector: tag store, pointers, counters
// and result registers. Depends on sutc_pkg and sutc_ram.
`timescale 1ns / 1ps

module sutc_dp
    import sutc_pkg::*;
#(
    parameter int MAX_TAGS = SUTC_MAX_TAGS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TAG_W-1:0]  i_tag,
    input  logic              i_last_of_list,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data,
    input  t_sutc_cmd         i_cmd,
    output t_sutc_stat        o_stat,
    output logic              o_strobe,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic              o_has_tag,
    output logic [CNT_W-1:0]  o_total_count,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last
);

    localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
    localparam int CW = $clog2(MAX_TAGS + 1);
    localparam int XW = CW + CNT_W;

    logic [TAG_W-1:0]  r_tag;
    logic              r_last_flag;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_count;
    logic              r_ovf;
    logic [CAP_W-1:0]  r_cap;

    logic              r_strobe;
    logic [TAG_W-1:0]  r_out_tag;
    logic              r_has_tag;
    logic [CNT_W-1:0]  r_total_count;
    logic [STAT_W-1:0] r_status;
    logic              r_out_last;

    logic [TAG_W-1:0]  rd_data;
    logic [CW-1:0]     j_minus;
    logic [AW-1:0]     raddr;
    logic [TAG_W-1:0]  wdata;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     cap_x;
    logic [CNT_W-1:0]  count_field;
    logic [CW:0]       idx_plus;
    logic [STAT_W-1:0] end_status;

    assign j_minus = r_j - CW'(1);
    assign raddr   = i_cmd.rd_shift ? j_minus[AW-1:0] : r_idx[AW-1:0];
    assign wdata   = i_cmd.wr_ins ? r_tag : rd_data;

    sutc_ram #(
        .WIDTH(TAG_W),
        .DEPTH(MAX_TAGS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_ins | i_cmd.wr_shift),
        .i_waddr(r_j[AW-1:0]),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd_idx | i_cmd.rd_shift),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    assign count_x     = {{CNT_W{1'b0}}, r_count};
    assign cap_x       = {{CW{1'b0}}, r_cap};
    assign count_field = (count_x > XW'(CNT_MAX)) ? CNT_MAX : count_x[CNT_W-1:0];
    assign idx_plus    = {1'b0, r_idx} + (CW + 1)'(1);

    // Overflow outranks a short consumer buffer.
    assign end_status = r_ovf ? ST_OVERFLOW : ((count_x > cap_x) ? ST_SHORT : ST_OK);

    always_comb begin
        o_stat              = '0;
        o_stat.idx_eq_count = (r_idx == r_count);
        o_stat.data_lt      = (rd_data < r_tag);
        o_stat.data_eq      = (rd_data == r_tag);
        o_stat.full         = ({1'b0, r_count} >= (CW + 1)'(MAX_TAGS));
        o_stat.j_eq_pos     = (r_j == r_pos);
        o_stat.last_flag    = r_last_flag;
        o_stat.ovf          = r_ovf;
        o_stat.gt_cap       = (count_x > cap_x);
        o_stat.count_zero   = (r_count == '0);
        o_stat.emit_last    = (idx_plus == {1'b0, r_count});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_cap    <= CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.inc_count) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.set_ovf) begin
                    r_ovf <= 1'b1;
                end
            end
            r_strobe <= i_cmd.emit_status | i_cmd.emit_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_tag       <= i_tag;
            r_last_flag <= i_last_of_list;
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.set_pos) begin
            r_pos <= r_idx;
        end
        if (i_cmd.set_j) begin
            r_j <= r_count;
        end else if (i_cmd.dec_j) begin
            r_j <= j_minus;
        end
        if (i_cmd.emit_status) begin
            r_out_tag     <= '0;
            r_has_tag     <= 1'b0;
            r_total_count <= count_field;
            r_status      <= end_status;
            r_out_last    <= 1'b1;
        end else if (i_cmd.emit_tag) begin
            r_out_tag     <= rd_data;
            r_has_tag     <= 1'b1;
            r_total_count <= count_field;
            r_status      <= ST_OK;
            r_out_last    <= o_stat.emit_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_tag     = r_out_tag;
    assign o_has_tag     = r_has_tag;
    assign o_total_count = r_total_count;
    assign o_status      = r_status;
    assign o_last        = r_out_last;

endmodule
